/* hdl/fcbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbd_pkg
// Shared types and constants of the fault code blink display.
// ----------------------------------------------------------------------------
package fcbd_pkg;

	localparam int CODE_W  = 16;
	localparam int CNT_W   = 16;
	localparam int TENS_W  = 14;
	localparam int UNITS_W = 5;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;

	// divide by ten: (x * 0xCCCD) >> 19 is exact for every 16-bit x
	localparam logic [CODE_W-1:0] DIV10_MAGIC = 16'hCCCD;
	localparam int DIV10_SHIFT = 19;

	localparam logic [PHASE_W-1:0] PH_INIT      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_TENS      = 3'd1;
	localparam logic [PHASE_W-1:0] PH_TENS_GAP  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_UNITS     = 3'd3;
	localparam logic [PHASE_W-1:0] PH_UNITS_GAP = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_FLASH_HALF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TENS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_UNITS  = 2'd2;

	localparam logic [CNT_W-1:0] FLASH_HALF_RST = 16'd100;
	localparam logic [CNT_W-1:0] GAP_TENS_RST   = 16'd800;
	localparam logic [CNT_W-1:0] GAP_UNITS_RST  = 16'd2000;

	typedef struct packed {
		logic [CNT_W-1:0] flash_half_period;
		logic [CNT_W-1:0] gap_after_tens;
		logic [CNT_W-1:0] gap_after_units;
	} cfg_t;

endpackage
`default_nettype wire

/* hdl/fcbd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbd_if
// Valid/ready channels for fault items, display results and register writes.
// ----------------------------------------------------------------------------
interface fcbd_item_if;
	logic                        valid;
	logic                        ready;
	logic [fcbd_pkg::CODE_W-1:0] core_fault;
	logic [fcbd_pkg::CODE_W-1:0] app_fault;
	logic                        run_active;

	modport source (output valid, output core_fault, output app_fault,
		output run_active, input ready);
	modport sink (input valid, input core_fault, input app_fault,
		input run_active, output ready);
endinterface

interface fcbd_result_if;
	logic                         valid;
	logic                         ready;
	logic                         led_on;
	logic [fcbd_pkg::PHASE_W-1:0] display_phase;

	modport source (output valid, output led_on, output display_phase, input ready);
	modport sink (input valid, input led_on, input display_phase, output ready);
endinterface

interface fcbd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fcbd_pkg::CFG_IDX_W-1:0] index;
	logic [fcbd_pkg::CNT_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/fault_code_blink_display.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fault_code_blink_display
// Blinks a fault code on one LED as a tens count and a units digit, one tick per item.
// ----------------------------------------------------------------------------
// Each accepted item is one tick. The block takes one item per clock cycle while
// results are taken, and returns one result per item: an input register
// feeds the divide-by-ten and the blink sequencer, whose state registers hold
// the result until it is taken. A stalled result holds one more item in the
// input register. Registers are written over the cfg channel, always ready,
// and take effect on the next tick.
// ----------------------------------------------------------------------------
module fault_code_blink_display (
	input  wire logic      clk,
	input  wire logic      arst_n,
	fcbd_item_if.sink      item,
	fcbd_result_if.source  result,
	fcbd_cfg_if.sink       cfg
);

	logic                        valid_s1;
	logic [fcbd_pkg::CODE_W-1:0] core_fault_s1;
	logic [fcbd_pkg::CODE_W-1:0] app_fault_s1;
	logic                        run_active_s1;
	logic                        res_valid_q;
	logic                        advance;
	logic                        step;
	fcbd_pkg::cfg_t              cfg_q;

	assign advance     = !res_valid_q || result.ready;
	assign step        = valid_s1 && advance;
	assign item.ready  = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flash_half_period <= fcbd_pkg::FLASH_HALF_RST;
			cfg_q.gap_after_tens    <= fcbd_pkg::GAP_TENS_RST;
			cfg_q.gap_after_units   <= fcbd_pkg::GAP_UNITS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				fcbd_pkg::REG_FLASH_HALF: cfg_q.flash_half_period <= cfg.data;
				fcbd_pkg::REG_GAP_TENS:   cfg_q.gap_after_tens    <= cfg.data;
				fcbd_pkg::REG_GAP_UNITS:  cfg_q.gap_after_units   <= cfg.data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			core_fault_s1 <= item.core_fault;
			app_fault_s1  <= item.app_fault;
			run_active_s1 <= item.run_active;
		end
	end

	fcbd_blink_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.core_fault    (core_fault_s1),
		.app_fault     (app_fault_s1),
		.run_active    (run_active_s1),
		.cfg           (cfg_q),
		.led_on        (result.led_on),
		.display_phase (result.display_phase)
	);

	assign result.valid = res_valid_q;

endmodule
`default_nettype wire

/* hdl/fcbd_digit_split.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbd_digit_split
// Splits a fault code into its tens count and units digit.
// ----------------------------------------------------------------------------
module fcbd_digit_split (
	input  wire logic [fcbd_pkg::CODE_W-1:0]  code,
	output logic      [fcbd_pkg::TENS_W-1:0]  tens,
	output logic      [fcbd_pkg::UNITS_W-1:0] units
);

	localparam int PROD_W = 2 * fcbd_pkg::CODE_W;
	localparam int QUOT_W = PROD_W - fcbd_pkg::DIV10_SHIFT;

	logic [PROD_W-1:0]           prod;
	logic [QUOT_W-1:0]           quot;
	logic [fcbd_pkg::CODE_W:0]   times_ten;
	logic [fcbd_pkg::CODE_W:0]   rem;

	assign prod      = {{fcbd_pkg::CODE_W{1'b0}}, code}
		* {{fcbd_pkg::CODE_W{1'b0}}, fcbd_pkg::DIV10_MAGIC};
	assign quot      = prod[PROD_W-1:fcbd_pkg::DIV10_SHIFT];
	// q * 10 as q * 8 + q * 2
	assign times_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
	assign rem       = {1'b0, code} - times_ten;
	assign tens      = {{(fcbd_pkg::TENS_W-QUOT_W){1'b0}}, quot};
	assign units     = rem[fcbd_pkg::UNITS_W-1:0];

endmodule
`default_nettype wire

/* hdl/fcbd_blink_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbd_blink_fsm
// Blink sequencer: phase, flash and pause counters, digit counts, LED level.
// ----------------------------------------------------------------------------
module fcbd_blink_fsm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [fcbd_pkg::CODE_W-1:0]   core_fault,
	input  wire logic [fcbd_pkg::CODE_W-1:0]   app_fault,
	input  wire logic                          run_active,
	input  wire fcbd_pkg::cfg_t                cfg,
	output logic                               led_on,
	output logic      [fcbd_pkg::PHASE_W-1:0]  display_phase
);

	localparam int CNT_W = fcbd_pkg::CNT_W;

	logic [fcbd_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [CNT_W-1:0]             flash_count_q, flash_count_d;
	logic [CNT_W-1:0]             gap_count_q, gap_count_d;
	logic [fcbd_pkg::TENS_W-1:0]  tens_q, tens_d;
	logic [fcbd_pkg::UNITS_W-1:0] units_q, units_d;
	logic                         led_q, led_d;

	logic [fcbd_pkg::CODE_W-1:0]  code;
	logic [fcbd_pkg::TENS_W-1:0]  split_tens;
	logic [fcbd_pkg::UNITS_W-1:0] split_units;
	logic [fcbd_pkg::TENS_W-1:0]  digit;
	logic [fcbd_pkg::TENS_W-1:0]  digit_dec;
	logic                         digit_done;
	logic [CNT_W:0]               flash_n;
	logic                         flash_lit;
	logic                         flash_dark;
	logic [CNT_W:0]               gap_n;
	logic [CNT_W-1:0]             gap_limit;
	logic                         gap_done;

	assign code = (core_fault != '0) ? core_fault : app_fault;

	fcbd_digit_split u_split (
		.code  (code),
		.tens  (split_tens),
		.units (split_units)
	);

	assign digit      = (phase_q == fcbd_pkg::PH_UNITS)
		? {{(fcbd_pkg::TENS_W-fcbd_pkg::UNITS_W){1'b0}}, units_q} : tens_q;
	assign digit_done = (digit <= fcbd_pkg::TENS_W'(1));
	assign digit_dec  = digit_done ? '0 : digit - fcbd_pkg::TENS_W'(1);

	assign flash_n    = {1'b0, flash_count_q} + (CNT_W+1)'(1);
	assign flash_lit  = !flash_n[CNT_W] && (flash_n < {1'b0, cfg.flash_half_period});
	assign flash_dark = !flash_n[CNT_W] && (flash_n < {cfg.flash_half_period, 1'b0});

	assign gap_limit  = (phase_q == fcbd_pkg::PH_UNITS_GAP)
		? cfg.gap_after_units : cfg.gap_after_tens;
	assign gap_n      = {1'b0, gap_count_q} + (CNT_W+1)'(1);
	assign gap_done   = gap_n > {1'b0, gap_limit};

	always_comb begin
		phase_d       = phase_q;
		flash_count_d = flash_count_q;
		gap_count_d   = gap_count_q;
		tens_d        = tens_q;
		units_d       = units_q;
		led_d         = led_q;
		if (code != '0) begin
			case (phase_q)
				fcbd_pkg::PH_INIT: begin
					tens_d  = split_tens;
					units_d = split_units;
					phase_d = fcbd_pkg::PH_TENS;
				end
				fcbd_pkg::PH_TENS, fcbd_pkg::PH_UNITS: begin
					if (flash_lit) begin
						flash_count_d = flash_n[CNT_W-1:0];
						led_d         = 1'b1;
					end else if (flash_dark) begin
						flash_count_d = flash_n[CNT_W-1:0];
						led_d         = 1'b0;
					end else begin
						flash_count_d = '0;
						if (phase_q == fcbd_pkg::PH_UNITS) begin
							units_d = digit_dec[fcbd_pkg::UNITS_W-1:0];
							if (digit_done)
								phase_d = fcbd_pkg::PH_UNITS_GAP;
						end else begin
							tens_d = digit_dec;
							if (digit_done)
								phase_d = fcbd_pkg::PH_TENS_GAP;
						end
					end
				end
				fcbd_pkg::PH_TENS_GAP, fcbd_pkg::PH_UNITS_GAP: begin
					led_d = 1'b0;
					if (gap_done) begin
						gap_count_d = '0;
						phase_d = (phase_q == fcbd_pkg::PH_TENS_GAP)
							? fcbd_pkg::PH_UNITS : fcbd_pkg::PH_INIT;
					end else begin
						gap_count_d = gap_n[CNT_W-1:0];
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end else begin
			led_d = ~run_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= fcbd_pkg::PH_INIT;
			flash_count_q <= '0;
			gap_count_q   <= '0;
			tens_q        <= '0;
			units_q       <= '0;
			led_q         <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			flash_count_q <= flash_count_d;
			gap_count_q   <= gap_count_d;
			tens_q        <= tens_d;
			units_q       <= units_d;
			led_q         <= led_d;
		end
	end

	assign led_on        = led_q;
	assign display_phase = phase_q;

endmodule
`default_nettype wire
